[hdl/itar_pkg.sv]
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, constants and helper functions of the integer to ASCII
// radix conversion unit.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int IDX_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DIGIT_MAX = RADIX_W'(35);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = CHAR_W'(55);

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < RADIX_W'(10)) begin
      return CHAR_ZERO + CHAR_W'(dc);
    end else begin
      return CHAR_ALPHA + CHAR_W'(dc);
    end
  endfunction

endpackage

[hdl/itar_front.sv]
// ----------------------------------------------------------------------------
// itar_front
// Input side: accepts items, masks the value and clamps the radix, and
// pushes the prepared job into the queue.
// ----------------------------------------------------------------------------
module itar_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  itar_pkg::in_item_t in_data,
  output logic               push,
  output itar_pkg::job_t     push_data,
  input  logic               q_full
);

  function automatic logic [itar_pkg::VALUE_BITS-1:0] mask_value(
    logic [itar_pkg::IN_VALUE_W-1:0] v
  );
    logic [itar_pkg::VALUE_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < itar_pkg::VALUE_BITS; i++) begin
      if (i < itar_pkg::IN_VALUE_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  logic [itar_pkg::RADIX_W-1:0] radix_clamped;

  always_comb begin
    case (in_data.radix) inside
      [6'd0:6'd1]:   radix_clamped = itar_pkg::RADIX_MIN;
      [6'd37:6'd63]: radix_clamped = itar_pkg::RADIX_MAX;
      default:       radix_clamped = in_data.radix;
    endcase
  end

  assign in_ready        = !q_full;
  assign push            = in_valid && !q_full;
  assign push_data.value = mask_value(in_data.value);
  assign push_data.radix = radix_clamped;

endmodule

[hdl/itar_queue.sv]
// ----------------------------------------------------------------------------
// itar_queue
// Two-entry job queue between the input side and the conversion engine.
// ----------------------------------------------------------------------------
module itar_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itar_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output itar_pkg::job_t pop_data
);

  itar_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_pop;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign do_pop   = pop && q_valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/itar_back.sv]
// ----------------------------------------------------------------------------
// itar_back
// Conversion engine: a one-bit-per-cycle restoring divider produces the
// digits least significant first into a digit buffer, which is then read
// out in reverse order through an output register.
// ----------------------------------------------------------------------------
module itar_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  itar_pkg::job_t      pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output itar_pkg::out_item_t out_data
);

  localparam int VB = itar_pkg::VALUE_BITS;

  itar_pkg::back_state_t            state;
  itar_pkg::back_state_t            state_next;
  logic [VB-1:0]                    dvd;
  logic [itar_pkg::RADIX_W-1:0]     rem;
  logic [itar_pkg::RADIX_W-1:0]     rdx;
  logic [itar_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [itar_pkg::CNT_W-1:0]       cnt;
  logic [itar_pkg::IDX_W-1:0]       emit_idx;
  logic [itar_pkg::RADIX_W-1:0]     digits [VB];

  logic [itar_pkg::RADIX_W:0]       trial;
  logic                             ge;
  logic [itar_pkg::RADIX_W-1:0]     rem_new;
  logic [VB-1:0]                    dvd_new;
  logic [itar_pkg::CNT_W-1:0]       cnt_inc;
  logic                             digit_done;
  logic                             finish;
  logic                             load_out;

  assign trial   = {rem, dvd[VB-1]};
  assign ge      = (trial >= {1'b0, rdx});
  assign rem_new = ge ? itar_pkg::RADIX_W'(trial - {1'b0, rdx})
                      : itar_pkg::RADIX_W'(trial);
  assign dvd_new = {dvd[VB-2:0], ge};
  assign cnt_inc = cnt + itar_pkg::CNT_W'(1);

  always_comb begin
    pop        = 1'b0;
    digit_done = 1'b0;
    finish     = 1'b0;
    load_out   = 1'b0;
    case (state)
      itar_pkg::ST_IDLE: begin
        pop = q_valid;
      end
      itar_pkg::ST_DIV: begin
        digit_done = (bit_cnt == itar_pkg::BIT_CNT_W'(VB - 1));
        finish     = digit_done &&
                     ((dvd_new == '0) || (cnt_inc == itar_pkg::CNT_W'(VB)));
      end
      itar_pkg::ST_EMIT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      itar_pkg::ST_IDLE: begin
        if (pop) begin
          state_next = itar_pkg::ST_DIV;
        end
      end
      itar_pkg::ST_DIV: begin
        if (finish) begin
          state_next = itar_pkg::ST_EMIT;
        end
      end
      itar_pkg::ST_EMIT: begin
        if (load_out && (emit_idx == '0)) begin
          state_next = itar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itar_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (digit_done) begin
      digits[cnt[itar_pkg::IDX_W-1:0]] <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt  <= '0;
      cnt      <= '0;
      emit_idx <= '0;
    end else begin
      if (pop) begin
        dvd     <= pop_data.value;
        rdx     <= pop_data.radix;
        rem     <= '0;
        bit_cnt <= '0;
        cnt     <= '0;
      end else if (state == itar_pkg::ST_DIV) begin
        dvd <= dvd_new;
        if (digit_done) begin
          rem      <= '0;
          bit_cnt  <= '0;
          cnt      <= cnt_inc;
          emit_idx <= cnt[itar_pkg::IDX_W-1:0];
        end else begin
          rem     <= rem_new;
          bit_cnt <= bit_cnt + itar_pkg::BIT_CNT_W'(1);
        end
      end else if (load_out) begin
        emit_idx <= emit_idx - itar_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.digit_char <= itar_pkg::digit_to_char(digits[emit_idx]);
      out_data.last       <= (emit_idx == '0);
    end
  end

endmodule

[hdl/integer_to_ascii_radix_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Converts an unsigned number to its ASCII digits in a radix from 2 to 36,
// most significant digit first, with the last digit flagged.
// ----------------------------------------------------------------------------
// An item with d digits (one digit for a zero value) occupies the conversion
// engine for one pass of the shared one-bit-per-cycle restoring divider per
// digit, and each digit then leaves through the output register when the
// sink is ready. The worst case is radix 2 with the top bit set. A two-entry
// queue lets up to two further items transfer in while a conversion runs.
// Radix codes below 2 are treated as 2 and codes above 36 as 36.
module integer_to_ascii_radix_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  itar_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output itar_pkg::out_item_t out_data
);

  logic           push;
  itar_pkg::job_t push_data;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  itar_pkg::job_t pop_data;

  itar_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  itar_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  itar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/itar_checker.sv]
// ----------------------------------------------------------------------------
// itar_checker
// Port-level checks of the integer to ASCII radix conversion unit.
// ----------------------------------------------------------------------------
module itar_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input itar_pkg::out_item_t out_data
);

  logic in_transfer;
  assign in_transfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result changed while stalled.");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.digit_char >= 7'd48 && out_data.digit_char <= 7'd57) ||
                   (out_data.digit_char >= 7'd65 && out_data.digit_char <= 7'd90)))
    else $error("Result is not a digit character.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result shown right after reset.");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && in_transfer |=> !out_valid)
    else $error("Result appeared one cycle after the first transfer.");

endmodule

bind integer_to_ascii_radix_unit itar_checker u_itar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
